[design/gtmt_pkg.sv]
package gtmt_pkg;

    localparam int HIT_KIND_W = 2;
    localparam int SLOT_W     = 6;
    localparam int SCORE_W    = 2;
    localparam int GROUP_W    = 3;
    localparam int KIND_W     = 2;
    localparam int KEY_W      = 32;
    localparam int ADDR_W     = 64;
    localparam int LINK_IN_W  = 16;

    localparam logic [GROUP_W-1:0] GRP_LOCAL_REMOTE = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_REMOTE       = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_LOCAL        = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_WILDCARD     = 3'd4;

    localparam logic [KIND_W-1:0] KIND_IP6GRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ETHER  = 2'd1;

    localparam logic [HIT_KIND_W-1:0] HIT_NONE     = 2'd0;
    localparam logic [HIT_KIND_W-1:0] HIT_TABLE    = 2'd1;
    localparam logic [HIT_KIND_W-1:0] HIT_FALLBACK = 2'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [7:0] MCAST_TOP = 8'hff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_NEXT,
        ST_DONE,
        ST_OUT,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic                  func;
        logic [SLOT_W-1:0]     slot;
        logic [GROUP_W-1:0]    entry_group;
        logic [ADDR_W-1:0]     local_addr_hi;
        logic [ADDR_W-1:0]     local_addr_lo;
        logic [ADDR_W-1:0]     remote_addr_hi;
        logic [ADDR_W-1:0]     remote_addr_lo;
        logic [KEY_W-1:0]      tunnel_key;
        logic [LINK_IN_W-1:0]  link_index;
        logic                  ether_frame;
        logic [KIND_W-1:0]     entry_kind;
        logic                  entry_up;
    } t_req;

    typedef struct packed {
        logic [HIT_KIND_W-1:0] hit_kind;
        logic [SLOT_W-1:0]     hit_slot;
        logic [SCORE_W-1:0]    hit_score;
    } t_rsp;

endpackage

[design/gtmt_req_if.sv]
interface gtmt_req_if import gtmt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/gtmt_rsp_if.sv]
interface gtmt_rsp_if import gtmt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/gtmt_ram.sv]
module gtmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/gre6_tunnel_match_table.sv]
// gre6_tunnel_match_table
// Tunnel match table with prioritized best-match lookup.
// Channels: i_req (sink) carries write or lookup requests; o_rsp (source)
// returns one response per request. i_fallback_we/i_fallback_up write the
// fallback-up register.
// A write request stores one slot and then responds; a slot at or above
// TABLE_SLOTS is not stored. A lookup scans groups in priority order;
// within each pass all TABLE_SLOTS slots are read through the shared
// table RAM and compared by one compare unit, in the steps read, compare,
// step per slot. A zero score ends the scan early.
// One request is handled at a time; i_req.ready is low while busy or
// while a response waits in the output register. The next request is
// taken in the cycle after the response is accepted, at the earliest.
// A stalled receiver holds the response and blocks new requests.
// Reset (synchronous, active low) clears control state and the fallback
// register; then a clearing pass empties every slot, with i_req.ready low.
module gre6_tunnel_match_table import gtmt_pkg::*; #(
    parameter int TABLE_SLOTS = 64,
    parameter int LINK_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fallback_we,
    input  logic       i_fallback_up,
    gtmt_req_if.sink   i_req,
    gtmt_rsp_if.source o_rsp
);
    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int ENT_W = GROUP_W + 4 * ADDR_W + KEY_W + LINK_BITS + KIND_W + 1;

    typedef struct packed {
        logic [GROUP_W-1:0]   grp;
        logic [ADDR_W-1:0]    lh;
        logic [ADDR_W-1:0]    ll;
        logic [ADDR_W-1:0]    rh;
        logic [ADDR_W-1:0]    rl;
        logic [KEY_W-1:0]     key;
        logic [LINK_BITS-1:0] link;
        logic [KIND_W-1:0]    kind;
        logic                 up;
    } t_ent;

    t_state r_state, n_state;
    logic   r_fb;
    t_req   r_req;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [GROUP_W-1:0] r_grp, n_grp;
    logic [2:0]         r_best, n_best;
    logic [IDX_W-1:0]   r_bslot, n_bslot;
    logic               r_match;
    logic [SCORE_W-1:0] r_score;
    t_rsp               r_rsp, n_rsp;
    logic               r_ovld, n_ovld;

    t_ent ent_w, ent_r, ram_wdata;
    logic [ENT_W-1:0] rdata;
    logic we;
    logic clr;
    logic ram_we;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] ram_waddr;
    logic [LINK_BITS-1:0] pkt_link;
    logic [KIND_W-1:0] want;
    logic slot_ok;

    assign slot_ok = ({{(32-SLOT_W){1'b0}}, i_req.data.slot} < 32'(TABLE_SLOTS));
    assign we = i_req.valid && i_req.ready && (i_req.data.func == FUNC_WRITE) && slot_ok;
    assign wr_slot = IDX_W'(i_req.data.slot);

    always_comb begin
        ent_w.grp  = i_req.data.entry_group;
        ent_w.lh   = i_req.data.local_addr_hi;
        ent_w.ll   = i_req.data.local_addr_lo;
        ent_w.rh   = i_req.data.remote_addr_hi;
        ent_w.rl   = i_req.data.remote_addr_lo;
        ent_w.key  = i_req.data.tunnel_key;
        ent_w.link = LINK_BITS'({{32{1'b0}}, i_req.data.link_index});
        ent_w.kind = i_req.data.entry_kind;
        ent_w.up   = i_req.data.entry_up;
    end

    // clearing pass after reset writes empty entries
    assign clr       = (r_state == ST_CLEAR);
    assign ram_we    = we || clr;
    assign ram_waddr = clr ? r_idx : wr_slot;
    assign ram_wdata = clr ? t_ent'('0) : ent_w;

    gtmt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );
    assign ent_r = t_ent'(rdata);

    assign pkt_link = LINK_BITS'({{32{1'b0}}, r_req.link_index});
    assign want = r_req.ether_frame ? KIND_ETHER : KIND_IP6GRE;

    // compare unit
    logic loc_eq, rem_eq, mc_eq, addr_ok, kind_ok, c_match;
    logic [GROUP_W-1:0] slot_grp;
    always_comb begin
        slot_grp = ent_r.grp;
        loc_eq = (r_req.local_addr_hi == ent_r.lh) && (r_req.local_addr_lo == ent_r.ll);
        rem_eq = (r_req.remote_addr_hi == ent_r.rh) && (r_req.remote_addr_lo == ent_r.rl);
        mc_eq  = (r_req.local_addr_hi == ent_r.rh) && (r_req.local_addr_lo == ent_r.rl)
                 && (r_req.local_addr_hi[ADDR_W-1 -: 8] == MCAST_TOP);
        unique case (r_grp)
            GRP_LOCAL_REMOTE: addr_ok = loc_eq && rem_eq;
            GRP_REMOTE:       addr_ok = rem_eq;
            GRP_LOCAL:        addr_ok = loc_eq || mc_eq;
            GRP_WILDCARD:     addr_ok = 1'b1;
            default:          addr_ok = 1'b0;
        endcase
        kind_ok = (ent_r.kind == KIND_IP6GRE) || (ent_r.kind == want);
        c_match = (slot_grp == r_grp) && ent_r.up && (ent_r.key == r_req.tunnel_key)
                  && addr_ok && kind_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_fb    <= 1'b0;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ovld  <= n_ovld;
            if (i_fallback_we) begin
                r_fb <= i_fallback_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        r_grp   <= n_grp;
        r_best  <= n_best;
        r_bslot <= n_bslot;
        r_rsp   <= n_rsp;
        r_match <= c_match;
        r_score <= {ent_r.kind != want, ent_r.link != pkt_link};
    end

    assign i_req.ready = (r_state == ST_IDLE) && !r_ovld;
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_grp   = r_grp;
        n_best  = r_best;
        n_bslot = r_bslot;
        n_rsp   = r_rsp;
        n_ovld  = r_ovld;
        if (o_rsp.valid && o_rsp.ready) begin
            n_ovld = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                if (32'(r_idx) == TABLE_SLOTS - 1) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_idx   = '0;
                    n_grp   = GRP_LOCAL_REMOTE;
                    n_best  = 3'd4;
                    n_bslot = '0;
                    n_state = (i_req.data.func == FUNC_LOOKUP) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP:  n_state = ST_NEXT;
            ST_NEXT: begin
                if (r_match && r_score == '0) begin
                    n_best  = '0;
                    n_bslot = r_idx;
                    n_state = ST_DONE;
                end else begin
                    if (r_match && {1'b0, r_score} < r_best) begin
                        n_best  = {1'b0, r_score};
                        n_bslot = r_idx;
                    end
                    if (32'(r_idx) == TABLE_SLOTS - 1) begin
                        n_idx = '0;
                        if (r_grp == GRP_WILDCARD) begin
                            n_state = ST_DONE;
                        end else begin
                            n_grp   = r_grp + 3'd1;
                            n_state = ST_READ;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_DONE: begin
                n_rsp.hit_kind  = HIT_NONE;
                n_rsp.hit_slot  = '0;
                n_rsp.hit_score = '0;
                if (r_req.func == FUNC_LOOKUP) begin
                    if (r_best != 3'd4) begin
                        n_rsp.hit_kind  = HIT_TABLE;
                        n_rsp.hit_slot  = SLOT_W'({{SLOT_W{1'b0}}, r_bslot});
                        n_rsp.hit_score = r_best[SCORE_W-1:0];
                    end else if (r_fb) begin
                        n_rsp.hit_kind = HIT_FALLBACK;
                    end
                end
                n_ovld  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
